// ===== rtl/character_stream_tokenizer_assert.svh =====
// Assertion macros for the character stream tokenizer.
// Each macro samples on the rising edge of i_clk and is disabled during reset.
`ifndef CHARACTER_STREAM_TOKENIZER_ASSERT_SVH
`define CHARACTER_STREAM_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CST_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CST_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Default width of the line and column counters
    localparam int POSITION_BITS_DEF = 16;

    // Fixed result field widths
    localparam int KIND_W = 5;
    localparam int POS_W  = 16;
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 31;

    localparam logic [VAL_W-1:0] INT_LIMIT = 31'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX   = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_US    = 8'h5F;  // underscore
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Input beat kinds
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOI  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_EOF       = 5'd0,
        K_IDENT     = 5'd1,
        K_INT       = 5'd2,
        K_PLUS      = 5'd3,
        K_MINUS     = 5'd4,
        K_STAR      = 5'd5,
        K_SLASH     = 5'd6,
        K_SEMI      = 5'd7,
        K_LPAREN    = 5'd8,
        K_RPAREN    = 5'd9,
        K_LBRACE    = 5'd10,
        K_RBRACE    = 5'd11,
        K_COMMA     = 5'd12,
        K_LT        = 5'd13,
        K_GT        = 5'd14,
        K_ASSIGN    = 5'd15,
        K_EQUAL     = 5'd16,
        K_NOT_EQUAL = 5'd17,
        K_UNKNOWN   = 5'd18,
        K_UNTERM    = 5'd19
    } t_kind;

    // One result beat
    typedef struct packed {
        logic              last;
        logic              out_of_range;
        logic [VAL_W-1:0]  token_value;
        logic [LEN_W-1:0]  token_length;
        logic [POS_W-1:0]  start_column;
        logic [POS_W-1:0]  start_line;
        t_kind             token_kind;
    } t_result;

    // Single-character punctuation; K_UNKNOWN when not one of them
    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        begin
            case (c)
                8'h2B:   k = K_PLUS;
                8'h2D:   k = K_MINUS;
                8'h2A:   k = K_STAR;
                8'h3B:   k = K_SEMI;
                8'h28:   k = K_LPAREN;
                8'h29:   k = K_RPAREN;
                8'h7B:   k = K_LBRACE;
                8'h7D:   k = K_RBRACE;
                8'h2C:   k = K_COMMA;
                8'h3C:   k = K_LT;
                8'h3E:   k = K_GT;
                default: k = K_UNKNOWN;
            endcase
            return k;
        end
    endfunction

    function automatic t_result mk_result(input t_kind k, input logic [POS_W-1:0] ln,
                                          input logic [POS_W-1:0] col,
                                          input logic [LEN_W-1:0] len,
                                          input logic [VAL_W-1:0] val, input logic oor);
        t_result r;
        begin
            r.token_kind   = k;
            r.start_line   = ln;
            r.start_column = col;
            r.token_length = len;
            r.token_value  = val;
            r.out_of_range = oor;
            r.last         = 1'b0;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/character_stream_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Character stream tokenizer.
// Slave channel (s_*): one beat per source byte (s_tuser = 0, byte in s_tdata)
// or an end-of-input beat (s_tuser = 1). Master channel (m_*): one beat per
// token; m_tlast marks the final token caused by one input beat.
// Every input beat updates the scan state and writes 0, 1 or 2
// tokens into a three-entry output queue whose head is the output register.
// Each token is registered into the queue with its causing beat.
// Throughput: one input beat per cycle while each beat yields at most one
// token and the receiver keeps up; s_tready is low while two or more tokens
// are queued, so a beat that yields two tokens holds off the next input
// beat until the receiver takes one of them.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost. End of input flushes any pending token (or reports an open block
// comment), sends eof and returns the scan state to its reset values.
// Reset (i_rst_n low, synchronous) empties the queue and sets line and column
// to 1 and the scanner to idle.
module character_stream_tokenizer #(
    parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] char_code
    input  wire         s_tuser,   // [0] op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,   // [4:0] token_kind, [20:5] start_line,
                                   // [36:21] start_column, [52:37] token_length,
                                   // [83:53] token_value, [84] out_of_range, zeros
    output logic        m_tlast    // last
);

    localparam int CW = (POSITION_BITS > cst_pkg::POS_W) ? POSITION_BITS : cst_pkg::POS_W;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_SLASH, M_EQ, M_BANG,
        M_LINE_COMMENT, M_BLOCK, M_BLOCK_STAR
    } t_mode;

    // Scan state
    t_mode                        r_mode, n_mode;
    logic [POSITION_BITS-1:0]     r_line, n_line;
    logic [POSITION_BITS-1:0]     r_col, n_col;
    logic [POSITION_BITS-1:0]     r_tok_line, n_tok_line;
    logic [POSITION_BITS-1:0]     r_tok_col, n_tok_col;
    logic [cst_pkg::LEN_W-1:0]    r_len, n_len;
    logic [cst_pkg::VAL_W-1:0]    r_acc, n_acc;
    logic                         r_ovf, n_ovf;

    // Output queue, entry 0 is the output register
    cst_pkg::t_result             r_q [3];
    cst_pkg::t_result             n_q [3];
    logic [1:0]                   r_count, n_count;

    logic       s_fire, m_fire;
    logic [7:0] c;
    logic       c_letter, c_digit;

    function automatic logic [cst_pkg::POS_W-1:0] clamp_pos(
            input logic [POSITION_BITS-1:0] v);
        logic [CW-1:0] w;
        begin
            w = CW'(v);
            if (w > CW'(cst_pkg::LEN_MAX)) begin
                w = CW'(cst_pkg::LEN_MAX);
            end
            return w[cst_pkg::POS_W-1:0];
        end
    endfunction

    function automatic logic [POSITION_BITS-1:0] inc_sat(
            input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = (r_count <= 2'd1);
    assign m_tvalid = (r_count != 2'd0);
    assign m_tlast  = r_q[0].last;
    assign m_tdata  = {3'b000, r_q[0].out_of_range, r_q[0].token_value,
                       r_q[0].token_length, r_q[0].start_column,
                       r_q[0].start_line, r_q[0].token_kind};

    assign c        = s_tdata;
    assign c_letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == cst_pkg::CH_US);
    assign c_digit  = (c inside {[8'h30:8'h39]});

    // Per-beat scanner: pending token flush, end of input, new lexeme start
    logic              flush, start;
    logic              f_v, s_v;
    cst_pkg::t_result  f_r, s_r;
    logic [34:0]       prod;
    cst_pkg::t_kind    sk;

    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_col      = r_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_len      = r_len;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        flush      = 1'b0;
        start      = 1'b0;
        f_v        = 1'b0;
        s_v        = 1'b0;
        f_r        = cst_pkg::mk_result(cst_pkg::K_EOF, '0, '0, '0, '0, 1'b0);
        s_r        = f_r;
        sk         = cst_pkg::single_kind(c);
        // acc * 10 + digit as shifts and adds
        prod       = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {27'd0, c - 8'h30};

        if (s_tuser == cst_pkg::OP_EOI) begin
            flush = 1'b1;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (c_letter || c_digit) begin
                        if (r_len != cst_pkg::LEN_MAX) n_len = r_len + 1'b1;
                        n_col = inc_sat(r_col);
                    end else begin
                        flush = 1'b1;
                        start = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (c_digit) begin
                        if (r_len != cst_pkg::LEN_MAX) n_len = r_len + 1'b1;
                        n_col = inc_sat(r_col);
                        if (!r_ovf) begin
                            if (prod > 35'(cst_pkg::INT_LIMIT)) begin
                                n_acc = cst_pkg::INT_LIMIT;
                                n_ovf = 1'b1;
                            end else begin
                                n_acc = prod[cst_pkg::VAL_W-1:0];
                            end
                        end
                    end else begin
                        flush = 1'b1;
                        start = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == cst_pkg::CH_SLASH) begin
                        n_col  = inc_sat(r_col);
                        n_mode = M_LINE_COMMENT;
                    end else if (c == cst_pkg::CH_STAR) begin
                        n_col  = inc_sat(r_col);
                        n_mode = M_BLOCK;
                    end else begin
                        flush = 1'b1;
                        start = 1'b1;
                    end
                end
                M_EQ, M_BANG: begin
                    if (c == cst_pkg::CH_EQ) begin
                        n_col  = inc_sat(r_col);
                        n_mode = M_IDLE;
                        s_v    = 1'b1;
                        s_r    = cst_pkg::mk_result(
                            (r_mode == M_EQ) ? cst_pkg::K_EQUAL : cst_pkg::K_NOT_EQUAL,
                            clamp_pos(r_tok_line), clamp_pos(r_tok_col),
                            16'd2, '0, 1'b0);
                    end else begin
                        flush = 1'b1;
                        start = 1'b1;
                    end
                end
                M_LINE_COMMENT: begin
                    if (c == cst_pkg::CH_NL) begin
                        start = 1'b1;
                    end else begin
                        n_col = inc_sat(r_col);
                    end
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    n_col = inc_sat(r_col);
                    if (c == cst_pkg::CH_NL) begin
                        n_line = inc_sat(r_line);
                        n_col  = POS_ONE;
                        n_mode = M_BLOCK;
                    end else if (c == cst_pkg::CH_STAR) begin
                        n_mode = M_BLOCK_STAR;
                    end else if (c == cst_pkg::CH_SLASH && r_mode == M_BLOCK_STAR) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_mode = M_BLOCK;
                    end
                end
                default: begin
                    start = 1'b1;
                end
            endcase
        end

        // Pending token, from the state before this beat
        if (flush) begin
            f_v = 1'b1;
            case (r_mode)
                M_IDENT: f_r = cst_pkg::mk_result(cst_pkg::K_IDENT, clamp_pos(r_tok_line),
                                                  clamp_pos(r_tok_col), r_len, '0, 1'b0);
                M_NUMBER: f_r = cst_pkg::mk_result(cst_pkg::K_INT, clamp_pos(r_tok_line),
                                                   clamp_pos(r_tok_col), r_len, r_acc, r_ovf);
                M_SLASH: f_r = cst_pkg::mk_result(cst_pkg::K_SLASH, clamp_pos(r_tok_line),
                                                  clamp_pos(r_tok_col), 16'd1, '0, 1'b0);
                M_EQ: f_r = cst_pkg::mk_result(cst_pkg::K_ASSIGN, clamp_pos(r_tok_line),
                                               clamp_pos(r_tok_col), 16'd1, '0, 1'b0);
                M_BANG: f_r = cst_pkg::mk_result(cst_pkg::K_UNKNOWN, clamp_pos(r_tok_line),
                                                 clamp_pos(r_tok_col), 16'd1,
                                                 31'(cst_pkg::CH_BANG), 1'b0);
                M_BLOCK, M_BLOCK_STAR: f_r = cst_pkg::mk_result(cst_pkg::K_UNTERM,
                                                  clamp_pos(r_tok_line),
                                                  clamp_pos(r_tok_col), 16'd2, '0, 1'b0);
                default: f_v = 1'b0;
            endcase
            n_mode = M_IDLE;
        end

        // End of input: eof at the current position, then back to reset values
        if (s_tuser == cst_pkg::OP_EOI) begin
            s_v        = 1'b1;
            s_r        = cst_pkg::mk_result(cst_pkg::K_EOF, clamp_pos(r_line),
                                            clamp_pos(r_col), '0, '0, 1'b0);
            n_mode     = M_IDLE;
            n_line     = POS_ONE;
            n_col      = POS_ONE;
            n_tok_line = POS_ONE;
            n_tok_col  = POS_ONE;
            n_len      = '0;
            n_acc      = '0;
            n_ovf      = 1'b0;
        end

        // First character of a new lexeme (line and column untouched so far)
        if (start) begin
            n_mode = M_IDLE;
            if (c == cst_pkg::CH_SP || c == cst_pkg::CH_TAB || c == cst_pkg::CH_CR) begin
                n_col = inc_sat(r_col);
            end else if (c == cst_pkg::CH_NL) begin
                n_line = inc_sat(r_line);
                n_col  = POS_ONE;
            end else begin
                n_tok_line = r_line;
                n_tok_col  = r_col;
                n_col      = inc_sat(r_col);
                if (c_letter) begin
                    n_mode = M_IDENT;
                    n_len  = 16'd1;
                end else if (c_digit) begin
                    n_mode = M_NUMBER;
                    n_len  = 16'd1;
                    n_acc  = 31'(c - 8'h30);
                    n_ovf  = 1'b0;
                end else if (c == cst_pkg::CH_SLASH) begin
                    n_mode = M_SLASH;
                end else if (c == cst_pkg::CH_EQ) begin
                    n_mode = M_EQ;
                end else if (c == cst_pkg::CH_BANG) begin
                    n_mode = M_BANG;
                end else begin
                    s_v = 1'b1;
                    s_r = cst_pkg::mk_result(sk, clamp_pos(r_line), clamp_pos(r_col), 16'd1,
                          (sk == cst_pkg::K_UNKNOWN) ? 31'(c) : 31'd0, 1'b0);
                end
            end
        end
    end

    // Queue update: pop the head, then append this beat's tokens in order
    logic [1:0]        nres, cp;
    cst_pkg::t_result  res0, res1;

    always_comb begin
        res0 = f_v ? f_r : s_r;
        res1 = s_r;
        nres = 2'(f_v) + 2'(s_v);
        if (!s_fire) begin
            nres = 2'd0;
        end
        res0.last = (nres == 2'd1);
        res1.last = 1'b1;
        cp = r_count - 2'(m_fire);
        if (m_fire) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_q[2] = r_q[2];
        end else begin
            n_q[0] = r_q[0];
            n_q[1] = r_q[1];
            n_q[2] = r_q[2];
        end
        for (int i = 0; i < 3; i++) begin
            if (nres != 2'd0 && cp == 2'(i)) begin
                n_q[i] = res0;
            end
            if (nres == 2'd2 && cp + 2'd1 == 2'(i)) begin
                n_q[i] = res1;
            end
        end
        n_count = cp + nres;
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
        if (!i_rst_n) begin
            r_count    <= 2'd0;
            r_mode     <= M_IDLE;
            r_line     <= POS_ONE;
            r_col      <= POS_ONE;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_len      <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_count <= n_count;
            if (s_fire) begin
                r_mode     <= n_mode;
                r_line     <= n_line;
                r_col      <= n_col;
                r_tok_line <= n_tok_line;
                r_tok_col  <= n_tok_col;
                r_len      <= n_len;
                r_acc      <= n_acc;
                r_ovf      <= n_ovf;
            end
        end
    end

    // Checks
    `include "character_stream_tokenizer_assert.svh"

    `CST_ASSERT_NEXT(a_eoi_resets, s_fire && s_tuser == cst_pkg::OP_EOI, r_mode == M_IDLE && r_line == POS_ONE && r_col == POS_ONE, "end of input did not restore reset state")
    `CST_ASSERT_IMPLY(a_eof_is_last, m_tvalid && r_q[0].token_kind == cst_pkg::K_EOF, m_tlast, "eof token not marked last")
    `CST_ASSERT_IMPLY(a_ovf_saturates, r_ovf, r_acc == cst_pkg::INT_LIMIT, "overflowed integer not saturated")

endmodule

`default_nettype wire

// ===== tb/sv/character_stream_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module character_stream_tokenizer_tb;

    localparam int PB           = cst_pkg::POSITION_BITS_DEF;
    localparam int POS_W        = cst_pkg::POS_W;
    localparam int LEN_W        = cst_pkg::LEN_W;
    localparam int VAL_W        = cst_pkg::VAL_W;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_BEATS = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_RUN     = 30;

    localparam string LEAD      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_TAIL = "abcdeXYZ_0123456789qQ";
    localparam string OP_CHARS  = "+-*/;(){},<>=!";
    localparam string WS_CHARS  = " \t\r\n";
    localparam string CMT_BODY  = "ab*/\n x";

    typedef logic [PB-1:0] t_pos;
    localparam t_pos POS_TOP = '1;

    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_NUMBER, SC_SLASH, SC_EQ, SC_BANG,
        SC_LINE_CMT, SC_BLOCK, SC_BLOCK_STAR
    } t_scan_mode;

    typedef struct packed {
        cst_pkg::t_kind   kind;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] val;
        logic             oor;
        logic             last;
    } t_token;

    // Token predictor and checker
    class token_scoreboard;
        t_scan_mode       mode;
        t_pos             row_no, col_no, tok_row, tok_col;
        logic [LEN_W-1:0] lex_len;
        logic [VAL_W-1:0] num_acc;
        logic             num_ovf;
        t_token           tokens_due[$];
        t_token           fresh[$];
        int               failures;

        function void clear_scan();
            mode    = SC_IDLE;
            row_no  = t_pos'(1);
            col_no  = t_pos'(1);
            tok_row = t_pos'(1);
            tok_col = t_pos'(1);
            lex_len = '0;
            num_acc = '0;
            num_ovf = 1'b0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function logic [15:0] sat16(t_pos v);
            if (v > 65535)
                return 16'hFFFF;
            return 16'(v);
        endfunction

        function void emit(cst_pkg::t_kind k, t_pos r, t_pos c, logic [LEN_W-1:0] len,
                           logic [VAL_W-1:0] val, logic oor);
            t_token t;
            t.kind = k;
            t.row  = sat16(r);
            t.col  = sat16(c);
            t.len  = len;
            t.val  = val;
            t.oor  = oor;
            t.last = 1'b0;
            fresh.insert(fresh.size(), t);
        endfunction

        function void step_col();
            if (col_no != POS_TOP)
                col_no = col_no + 1'b1;
        endfunction

        function void step_line();
            if (row_no != POS_TOP)
                row_no = row_no + 1'b1;
            col_no = t_pos'(1);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == cst_pkg::CH_US;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function cst_pkg::t_kind punct_kind(logic [7:0] c);
            case (c)
                "+":     return cst_pkg::K_PLUS;
                "-":     return cst_pkg::K_MINUS;
                "*":     return cst_pkg::K_STAR;
                ";":     return cst_pkg::K_SEMI;
                "(":     return cst_pkg::K_LPAREN;
                ")":     return cst_pkg::K_RPAREN;
                "{":     return cst_pkg::K_LBRACE;
                "}":     return cst_pkg::K_RBRACE;
                ",":     return cst_pkg::K_COMMA;
                "<":     return cst_pkg::K_LT;
                ">":     return cst_pkg::K_GT;
                default: return cst_pkg::K_UNKNOWN;
            endcase
        endfunction

        // byte seen with nothing pending
        function void start_char(logic [7:0] c);
            cst_pkg::t_kind k;
            mode = SC_IDLE;
            if (c == cst_pkg::CH_SP || c == cst_pkg::CH_TAB || c == cst_pkg::CH_CR) begin
                step_col();
                return;
            end
            if (c == cst_pkg::CH_NL) begin
                step_col();
                step_line();
                return;
            end
            tok_row = row_no;
            tok_col = col_no;
            step_col();
            if (is_letter(c)) begin
                mode    = SC_WORD;
                lex_len = LEN_W'(1);
                return;
            end
            if (is_digit(c)) begin
                mode    = SC_NUMBER;
                lex_len = LEN_W'(1);
                num_acc = VAL_W'(c - "0");
                num_ovf = 1'b0;
                return;
            end
            if (c == cst_pkg::CH_SLASH) begin
                mode = SC_SLASH;
                return;
            end
            if (c == cst_pkg::CH_EQ) begin
                mode = SC_EQ;
                return;
            end
            if (c == cst_pkg::CH_BANG) begin
                mode = SC_BANG;
                return;
            end
            k = punct_kind(c);
            if (k != cst_pkg::K_UNKNOWN)
                emit(k, tok_row, tok_col, LEN_W'(1), '0, 1'b0);
            else
                emit(cst_pkg::K_UNKNOWN, tok_row, tok_col, LEN_W'(1), VAL_W'(c), 1'b0);
        endfunction

        // close whatever token or comment is open
        function void flush_pending();
            case (mode)
                SC_WORD:   emit(cst_pkg::K_IDENT, tok_row, tok_col, lex_len, '0, 1'b0);
                SC_NUMBER: emit(cst_pkg::K_INT, tok_row, tok_col, lex_len, num_acc, num_ovf);
                SC_SLASH:  emit(cst_pkg::K_SLASH, tok_row, tok_col, LEN_W'(1), '0, 1'b0);
                SC_EQ:     emit(cst_pkg::K_ASSIGN, tok_row, tok_col, LEN_W'(1), '0, 1'b0);
                SC_BANG:   emit(cst_pkg::K_UNKNOWN, tok_row, tok_col, LEN_W'(1),
                                VAL_W'(cst_pkg::CH_BANG), 1'b0);
                SC_BLOCK, SC_BLOCK_STAR:
                           emit(cst_pkg::K_UNTERM, tok_row, tok_col, LEN_W'(2), '0, 1'b0);
                default: ;
            endcase
            mode = SC_IDLE;
        endfunction

        function void scan_char(logic [7:0] c);
            logic [63:0] v;
            logic [7:0]  dig;
            case (mode)
                SC_WORD: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (lex_len != cst_pkg::LEN_MAX)
                            lex_len = lex_len + 1'b1;
                        step_col();
                    end else begin
                        flush_pending();
                        start_char(c);
                    end
                end
                SC_NUMBER: begin
                    if (is_digit(c)) begin
                        if (lex_len != cst_pkg::LEN_MAX)
                            lex_len = lex_len + 1'b1;
                        step_col();
                        if (!num_ovf) begin
                            dig = c - "0";
                            v   = 64'(num_acc) * 64'd10 + 64'(dig);
                            if (v > 64'(cst_pkg::INT_LIMIT)) begin
                                num_acc = cst_pkg::INT_LIMIT;
                                num_ovf = 1'b1;
                            end else begin
                                num_acc = v[VAL_W-1:0];
                            end
                        end
                    end else begin
                        flush_pending();
                        start_char(c);
                    end
                end
                SC_SLASH: begin
                    if (c == cst_pkg::CH_SLASH) begin
                        step_col();
                        mode = SC_LINE_CMT;
                    end else if (c == cst_pkg::CH_STAR) begin
                        step_col();
                        mode = SC_BLOCK;
                    end else begin
                        flush_pending();
                        start_char(c);
                    end
                end
                SC_EQ, SC_BANG: begin
                    if (c == cst_pkg::CH_EQ) begin
                        step_col();
                        emit(mode == SC_EQ ? cst_pkg::K_EQUAL : cst_pkg::K_NOT_EQUAL,
                             tok_row, tok_col, LEN_W'(2), '0, 1'b0);
                        mode = SC_IDLE;
                    end else begin
                        flush_pending();
                        start_char(c);
                    end
                end
                SC_LINE_CMT: begin
                    // newline ends the comment and is then plain whitespace
                    if (c == cst_pkg::CH_NL)
                        start_char(c);
                    else
                        step_col();
                end
                SC_BLOCK, SC_BLOCK_STAR: begin
                    step_col();
                    if (c == cst_pkg::CH_NL) begin
                        step_line();
                        mode = SC_BLOCK;
                    end else if (c == cst_pkg::CH_STAR) begin
                        mode = SC_BLOCK_STAR;
                    end else if (c == cst_pkg::CH_SLASH && mode == SC_BLOCK_STAR) begin
                        mode = SC_IDLE;
                    end else begin
                        mode = SC_BLOCK;
                    end
                end
                default: start_char(c);
            endcase
        endfunction

        // accepted input beat: predict the tokens it causes
        function void note_beat(logic op, logic [7:0] c);
            fresh.delete();
            if (op == cst_pkg::OP_EOI) begin
                flush_pending();
                emit(cst_pkg::K_EOF, row_no, col_no, '0, '0, 1'b0);
                clear_scan();
            end else begin
                scan_char(c);
            end
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i])
                tokens_due.insert(tokens_due.size(), fresh[i]);
        endfunction

        function string tok_str(t_token t);
            return $sformatf("kind %0d line %0d col %0d len %0d val %0d oor %0b last %0b",
                             t.kind, t.row, t.col, t.len, t.val, t.oor, t.last);
        endfunction

        function void log_fail(string s);
            failures++;
            if (failures <= 10)
                $display("%0t mismatch: %s", $time, s);
        endfunction

        // accepted output beat: compare with the oldest prediction
        function void check_token(logic [87:0] d, logic lst);
            t_token got, want;
            got.kind = cst_pkg::t_kind'(d[4:0]);
            got.row  = d[20:5];
            got.col  = d[36:21];
            got.len  = d[52:37];
            got.val  = d[83:53];
            got.oor  = d[84];
            got.last = lst;
            if (tokens_due.size() == 0) begin
                log_fail({"token with nothing predicted: ", tok_str(got)});
                return;
            end
            want = tokens_due.pop_front();
            if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
                got.len !== want.len || got.val !== want.val || got.oor !== want.oor ||
                got.last !== want.last || d[87:85] !== 3'b000)
                log_fail({"expected ", tok_str(want), " / got ", tok_str(got),
                          $sformatf(" pad %0h", d[87:85])});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] char_code
    logic        s_tuser  = 1'b0;   // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;           // [4:0] kind, [20:5] line, [36:21] column,
                                    // [52:37] length, [83:53] value, [84] out_of_range
    logic        m_tlast;

    token_scoreboard sb;
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int gap_left    = 0;
    int beats_sent  = 0;
    int stall_cycles = 0;

    character_stream_tokenizer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Token sink: short random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                m_tready <= 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_token(m_tdata, m_tlast);
    end

    // Watchdog on cycles without any beat on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL character_stream_tokenizer");
            $finish;
        end
    end

    // One input beat, with an optional idle burst in front
    task automatic put_beat(logic op, logic [7:0] c);
        if (src_idle_on && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= c;
        do @(posedge i_clk); while (!s_tready);
        sb.note_beat(op, c);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_beat(cst_pkg::OP_CHAR, s[i]);
    endtask

    task automatic end_input();
        put_beat(cst_pkg::OP_EOI, 8'($urandom_range(0, 255)));
    endtask

    // One random lexeme, comment, blank run, noise byte, broken form or eof
    task automatic rand_fragment();
        int pick;
        int n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            put_beat(cst_pkg::OP_CHAR, LEAD[$urandom_range(0, LEAD.len() - 1)]);
            repeat ($urandom_range(0, 10))
                put_beat(cst_pkg::OP_CHAR,
                         WORD_TAIL[$urandom_range(0, WORD_TAIL.len() - 1)]);
        end else if (pick < 40) begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) put_beat(cst_pkg::OP_CHAR, "0");
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
            repeat (n) begin
                c = 8'("0" + $urandom_range(0, 9));
                put_beat(cst_pkg::OP_CHAR, c);
            end
        end else if (pick < 55) begin
            n = $urandom_range(0, OP_CHARS.len() + 1);
            if (n == OP_CHARS.len())
                send_text("==");
            else if (n == OP_CHARS.len() + 1)
                send_text("!=");
            else
                put_beat(cst_pkg::OP_CHAR, OP_CHARS[n]);
        end else if (pick < 72) begin
            repeat ($urandom_range(1, 3))
                put_beat(cst_pkg::OP_CHAR, WS_CHARS[$urandom_range(0, WS_CHARS.len() - 1)]);
        end else if (pick < 78) begin
            send_text("//");
            repeat ($urandom_range(0, 12))
                put_beat(cst_pkg::OP_CHAR, 8'($urandom_range(32, 126)));
            put_beat(cst_pkg::OP_CHAR, cst_pkg::CH_NL);
        end else if (pick < 84) begin
            send_text("/*");
            repeat ($urandom_range(0, 12))
                put_beat(cst_pkg::OP_CHAR, CMT_BODY[$urandom_range(0, CMT_BODY.len() - 1)]);
            send_text("*/");
        end else if (pick < 95) begin
            put_beat(cst_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            // broken forms: open comment with no close, bang on its own
            if (pick == 95)
                send_text("/*");
            else
                send_text("!");
        end else begin
            end_input();
        end
    endtask

    initial begin
        int rand_base;
        int pos;
        bit hold_done;
        bit pause_done;
        sb = new;
        sb.clear_scan();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: word and number edges, all operators, odd bytes, comments
        send_text("_Az9 007 2147483647 2147483648\t\r");
        put_beat(cst_pkg::OP_CHAR, 8'h0C);  // form feed
        put_beat(cst_pkg::OP_CHAR, 8'h0B);  // vertical tab
        send_text("==!=!x=");
        put_beat(cst_pkg::OP_CHAR, 8'h80);
        put_beat(cst_pkg::OP_CHAR, 8'hFF);
        put_beat(cst_pkg::OP_CHAR, 8'h00);
        send_text("+-*;(){},<>/ /*/\n*/b//c\nq");
        end_input();
        send_text("!");
        end_input();
        send_text("x/*");
        end_input();
        end_input();

        // random part, with one long sink hold-off and one full drain pause
        rand_base = beats_sent;
        while (beats_sent - rand_base < RANDOM_BEATS) begin
            pos = beats_sent - rand_base;
            src_idle_on = !(pos >= 450 && pos < 550);
            snk_idle_on = !(pos >= 450 && pos < 550);
            if (!hold_done && pos >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && pos >= 600) begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            rand_fragment();
        end

        // closing part, no idling: a long word, a run of newlines, a short tail
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        end_input();
        put_beat(cst_pkg::OP_CHAR, LEAD[$urandom_range(0, LEAD.len() - 1)]);
        repeat (LONG_RUN - 1)
            put_beat(cst_pkg::OP_CHAR, WORD_TAIL[$urandom_range(0, WORD_TAIL.len() - 1)]);
        end_input();
        repeat (LONG_RUN) put_beat(cst_pkg::OP_CHAR, cst_pkg::CH_NL);
        send_text("+ 12");
        end_input();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("PASS character_stream_tokenizer");
        else
            $display("FAIL character_stream_tokenizer");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/character_stream_tokenizer.sv
tb/sv/character_stream_tokenizer_tb.sv
